// ===== rtl/core/jmse_pkg.sv =====
// Shared types, codes and constants for the JTAG host shift engine.
package jmse_pkg;

    localparam int DATA_W        = 64;
    localparam int LEN_W         = 7;
    localparam int IR_LEN_W      = 6;
    localparam int KIND_W        = 2;
    localparam int MAX_SHIFT     = 64;
    localparam int SHIFT_IDX_W   = $clog2(MAX_SHIFT);
    localparam int RESET_CLOCKS  = 6;
    localparam int IR_MAX        = 32;
    localparam int NAV_STEPS_IR  = 4;
    localparam int NAV_STEPS_DR  = 3;

    localparam logic [IR_LEN_W-1:0] IR_LENGTH_RESET = IR_LEN_W'(5);

    // Request function codes.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Command kinds.
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IR    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DR    = 2'd2;

    typedef struct packed {
        logic              func;
        logic [KIND_W-1:0] command_kind;
        logic [DATA_W-1:0] shift_data;
        logic [LEN_W-1:0]  shift_length;
        logic              tdo_sample;
    } cmd_t;

    typedef struct packed {
        logic              clock_pulse;
        logic              tms_level;
        logic              tdi_level;
        logic              trst_n_level;
        logic [DATA_W-1:0] captured_bits;
        logic              done_res;
        logic              rejected;
    } res_t;

endpackage

// ===== rtl/core/jtag_master_shift_engine.sv =====
// JTAG host shift engine top level: a sequencer followed by a result buffer.
// Each request (a command, or one TCK tick) gives exactly one result, registered
// in the result buffer and shown on the result port, or held back there while the
// result side stalls; the engine takes one request every clock unless cmd_stall is
// high, and the two-entry result buffer lets it take one more request after the
// result side starts to stall.
// A tick's TCK cycle, its TMS, TDI and nTRST levels, and the TDO sample it
// carries are all handled within that single request. The IR length register is
// always ready and should only be written while no sequence is running.
module jtag_master_shift_engine import jmse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  cmd_t                cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output res_t                res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IR_LEN_W-1:0] cfg_data
);

    logic cmd_fire;
    res_t step_res;

    assign cfg_ready = 1'b1;
    assign cmd_fire  = cmd_valid && !cmd_stall;

    jmse_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .item_fire (cmd_fire),
        .item      (cmd),
        .result    (step_res)
    );

    jmse_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cmd_valid),
        .up_stall (cmd_stall),
        .up_data  (step_res),
        .dn_valid (res_valid),
        .dn_stall (res_stall),
        .dn_data  (res)
    );

endmodule

// ===== rtl/core/jmse_engine.sv =====
// TAP sequencer: holds the sequence state and works out one result per request.
module jmse_engine import jmse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IR_LEN_W-1:0] cfg_data,
    input  logic                item_fire,
    input  cmd_t                item,
    output res_t                result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_HOLD,
        PH_RST_REL,
        PH_NAV,
        PH_SHIFT,
        PH_UPDATE,
        PH_RUNIDLE
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    cc_reg, cc_next;
    logic [DATA_W-1:0]   out_shift_reg, out_shift_next;
    logic [DATA_W-1:0]   in_collect_reg, in_collect_next;
    logic [LEN_W-1:0]    active_length_reg, active_length_next;
    logic [KIND_W-1:0]   active_kind_reg, active_kind_next;
    logic [IR_LEN_W-1:0] ir_length_reg;

    logic [LEN_W-1:0]    cc_inc;
    logic [LEN_W-1:0]    ir_eff;
    logic [LEN_W-1:0]    dr_eff;
    logic [LEN_W-1:0]    nav_steps;
    logic                shift_last;

    assign cc_inc = cc_reg + LEN_W'(1);

    // Lengths outside the legal range are pinned to the nearest limit.
    always_comb
    begin
        if (ir_length_reg == '0)
            ir_eff = LEN_W'(1);
        else if ({1'b0, ir_length_reg} > LEN_W'(IR_MAX))
            ir_eff = LEN_W'(IR_MAX);
        else
            ir_eff = {1'b0, ir_length_reg};

        if (item.shift_length == '0)
            dr_eff = LEN_W'(1);
        else if (item.shift_length > LEN_W'(MAX_SHIFT))
            dr_eff = LEN_W'(MAX_SHIFT);
        else
            dr_eff = item.shift_length;
    end

    assign nav_steps  = (active_kind_reg == KIND_IR) ? LEN_W'(NAV_STEPS_IR)
                                                     : LEN_W'(NAV_STEPS_DR);
    assign shift_last = (cc_inc >= active_length_reg);

    always_comb
    begin
        phase_next         = phase_reg;
        cc_next            = cc_reg;
        out_shift_next     = out_shift_reg;
        in_collect_next    = in_collect_reg;
        active_length_next = active_length_reg;
        active_kind_next   = active_kind_reg;

        result.clock_pulse  = 1'b0;
        result.tms_level    = 1'b0;
        result.tdi_level    = 1'b0;
        result.trst_n_level = 1'b1;
        result.done_res     = 1'b0;
        result.rejected     = 1'b0;

        if (item.func == FUNC_START)
        begin
            if (phase_reg != PH_IDLE)
            begin
                result.rejected = 1'b1;
            end
            else
            begin
                case (item.command_kind)
                    KIND_RESET:
                    begin
                        active_kind_next = item.command_kind;
                        cc_next          = '0;
                        in_collect_next  = '0;
                        out_shift_next   = item.shift_data;
                        phase_next       = PH_RST_HOLD;
                    end
                    KIND_IR:
                    begin
                        active_kind_next   = item.command_kind;
                        cc_next            = '0;
                        in_collect_next    = '0;
                        out_shift_next     = item.shift_data;
                        active_length_next = ir_eff;
                        phase_next         = PH_NAV;
                    end
                    KIND_DR:
                    begin
                        active_kind_next   = item.command_kind;
                        cc_next            = '0;
                        in_collect_next    = '0;
                        out_shift_next     = item.shift_data;
                        active_length_next = dr_eff;
                        phase_next         = PH_NAV;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else
        begin
            case (phase_reg)
                PH_RST_HOLD:
                begin
                    result.clock_pulse  = 1'b1;
                    result.tms_level    = 1'b1;
                    result.trst_n_level = 1'b0;
                    cc_next             = cc_inc;
                    if (cc_inc >= LEN_W'(RESET_CLOCKS))
                        phase_next = PH_RST_REL;
                end
                PH_RST_REL:
                begin
                    result.clock_pulse = 1'b1;
                    result.done_res    = 1'b1;
                    cc_next            = '0;
                    phase_next         = PH_IDLE;
                end
                PH_NAV:
                begin
                    // IR walks TMS 1,1,0,0 and DR walks 1,0,0 from Run-Test/Idle.
                    result.clock_pulse = 1'b1;
                    if (active_kind_reg == KIND_IR)
                        result.tms_level = (cc_reg < LEN_W'(2));
                    else
                        result.tms_level = (cc_reg == '0);
                    cc_next = cc_inc;
                    if (cc_inc >= nav_steps)
                    begin
                        cc_next    = '0;
                        phase_next = PH_SHIFT;
                    end
                end
                PH_SHIFT:
                begin
                    result.clock_pulse = 1'b1;
                    result.tdi_level   = out_shift_reg[0];
                    result.tms_level   = shift_last;
                    in_collect_next    = in_collect_reg
                                       | ({{(DATA_W-1){1'b0}}, item.tdo_sample}
                                          << cc_reg[SHIFT_IDX_W-1:0]);
                    out_shift_next     = out_shift_reg >> 1;
                    cc_next            = cc_inc;
                    if (shift_last)
                    begin
                        cc_next    = '0;
                        phase_next = PH_UPDATE;
                    end
                end
                PH_UPDATE:
                begin
                    result.clock_pulse = 1'b1;
                    result.tms_level   = 1'b1;
                    phase_next         = PH_RUNIDLE;
                end
                PH_RUNIDLE:
                begin
                    result.clock_pulse = 1'b1;
                    result.done_res    = 1'b1;
                    phase_next         = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        result.captured_bits = in_collect_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            cc_reg            <= '0;
            out_shift_reg     <= '0;
            in_collect_reg    <= '0;
            active_length_reg <= '0;
            active_kind_reg   <= '0;
            ir_length_reg     <= IR_LENGTH_RESET;
        end
        else
        begin
            if (cfg_we)
                ir_length_reg <= cfg_data;
            if (item_fire)
            begin
                phase_reg         <= phase_next;
                cc_reg            <= cc_next;
                out_shift_reg     <= out_shift_next;
                in_collect_reg    <= in_collect_next;
                active_length_reg <= active_length_next;
                active_kind_reg   <= active_kind_next;
            end
        end
    end

endmodule

// ===== rtl/core/jmse_out_buf.sv =====
// Two-entry result buffer so a new request is taken while a result waits.
module jmse_out_buf import jmse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_stall,
    input  res_t up_data,
    output logic dn_valid,
    input  logic dn_stall,
    output res_t dn_data
);

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;
    logic up_fire;
    logic main_free;

    assign up_stall  = skid_valid_reg;
    assign up_fire   = up_valid && !skid_valid_reg;
    assign main_free = !main_valid_reg || !dn_stall;
    assign dn_valid  = main_valid_reg;
    assign dn_data   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= up_fire;
            end
        end
        else if (up_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (up_fire)
                main_reg <= up_data;
        end
        else if (up_fire)
        begin
            skid_reg <= up_data;
        end
    end

endmodule

// ===== rtl/core/jmse_checker.sv =====
// Port-level checks for the JTAG host shift engine, bound to its top level.
module jmse_checker import jmse_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_stall,
    input res_t                res
);

    // A stalled result stays on the port unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // A sequence only finishes on a driven TCK cycle.
    a_done_clocked: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.done_res |-> res.clock_pulse)
        else $error("done without a TCK cycle");

    // A rejected request drives no clock and ends nothing.
    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.rejected |-> !res.clock_pulse && !res.done_res)
        else $error("rejected request drove the TAP");

    // Test reset is only asserted during a clocked TMS-high hold.
    a_trst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.trst_n_level |-> res.tms_level && res.clock_pulse)
        else $error("nTRST low outside the reset hold");

    // TDI is only driven high on a clocked cycle.
    a_tdi_clocked: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.tdi_level |-> res.clock_pulse)
        else $error("TDI high without a TCK cycle");

endmodule

bind jtag_master_shift_engine jmse_checker u_jmse_checker (.*);
